### hdl/lsau_pkg.sv
// ----------------------------------------------------------------------------
// lsau_pkg
// Types, codes and sizes shared by the load/store address unit.
// ----------------------------------------------------------------------------
package lsau_pkg;

  // Pending buffer depth and the number of tag bits that are compared.
  localparam int BUFFER_DEPTH = 16;
  localparam int TAG_BITS     = 6;
  localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH + 1);

  // Request kinds.
  localparam logic [1:0] KIND_ISSUE = 2'd0;
  localparam logic [1:0] KIND_BCAST = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // One pending buffer entry.
  typedef struct packed {
    logic                is_store;
    logic                resolved;
    logic [TAG_BITS-1:0] tag;
    logic [5:0]          rob;
    logic [31:0]         addr;
  } pend_t;

  localparam int ENTRY_W = $bits(pend_t);

  // One result without its last mark.
  typedef struct packed {
    logic        status;
    logic        to_load_buffer;
    logic [5:0]  entry_rob;
    logic [31:0] address;
  } result_t;

  // Push and finish requests into the output stage.
  typedef struct packed {
    logic    push;
    logic    finish;
    result_t data;
  } emit_req_t;

  // Output stage status back to the controller.
  typedef struct packed {
    logic can_push;
    logic hold_valid;
  } emit_stat_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PROC,
    ST_FIN
  } state_t;

  // Scan pass kinds.
  typedef enum logic {
    PASS_BCAST,
    PASS_REL
  } pass_t;

endpackage

### hdl/lsau_if.sv
// ----------------------------------------------------------------------------
// lsau_if
// Request and result channels of the load/store address unit.
// ----------------------------------------------------------------------------
interface lsau_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               is_store;
  logic signed [31:0] offset;
  logic               operand_ready;
  logic [5:0]         src_tag;
  logic signed [31:0] src_value;
  logic [5:0]         rob_index;

  modport source (output valid, kind, is_store, offset, operand_ready, src_tag,
                  src_value, rob_index, input ready);
  modport sink (input valid, kind, is_store, offset, operand_ready, src_tag,
                src_value, rob_index, output ready);
endinterface

interface lsau_res_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               to_load_buffer;
  logic [5:0]         entry_rob;
  logic signed [31:0] address;
  logic               last;

  modport source (output valid, status, to_load_buffer, entry_rob, address, last,
                  input ready);
  modport sink (input valid, status, to_load_buffer, entry_rob, address, last,
                output ready);
endinterface

### hdl/load_store_address_unit_top.sv
// ----------------------------------------------------------------------------
// load_store_address_unit_top
// Address unit with an ordered pending buffer held in a synchronous RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. A ready load issue that finds room and
// every broadcast run compaction scans over the pending buffer through its
// single RAM read port; each entry is read in ST_READ and decided in ST_PROC.
// A broadcast makes a matching pass and then a load release pass. A scan
// waits in ST_PROC while the result channel is blocked. Each scan writes
// kept entries back packed toward the head, which removes released entries
// in place.
module load_store_address_unit_top import lsau_pkg::*; (
  input logic        clk,
  input logic        rst,
  lsau_req_if.sink   req_in,
  lsau_res_if.source res_out
);

  state_t state, state_next;
  pass_t  pass;
  logic [PTR_W-1:0]    count;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    wr_ptr;
  logic                stop;
  logic [TAG_BITS-1:0] bc_tag;
  logic [31:0]         bc_value;

  logic                accept;
  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata, mem_rdata;
  pend_t               entry, entry_upd, new_entry;
  logic                proc_emit, proc_keep, stall, pass_done;
  logic                bc_match;
  logic [31:0]         sum_addr;
  emit_req_t           ereq;
  emit_stat_t          estat;

  assign req_in.ready = (state == ST_IDLE);
  assign accept       = req_in.valid && req_in.ready;
  assign entry        = pend_t'(mem_rdata);
  assign sum_addr     = entry.addr + bc_value;
  assign bc_match     = !entry.resolved && (entry.tag == bc_tag);
  assign pass_done    = (rd_ptr == count);

  lsau_ram #(.DEPTH(BUFFER_DEPTH), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  lsau_outstage u_out (
    .clk  (clk),
    .rst  (rst),
    .req  (ereq),
    .stat (estat),
    .res  (res_out)
  );

  // Entry built from an issue request.
  always_comb begin
    new_entry.is_store = req_in.is_store;
    new_entry.resolved = req_in.operand_ready;
    new_entry.tag      = TAG_BITS'(req_in.src_tag);
    new_entry.rob      = req_in.rob_index;
    new_entry.addr     = req_in.operand_ready ?
                         32'(req_in.offset + req_in.src_value) : req_in.offset;
  end

  // Per-entry decision of the current scan pass.
  always_comb begin
    entry_upd = entry;
    proc_emit = 1'b0;
    if (pass == PASS_BCAST) begin
      if (bc_match) begin
        entry_upd.addr     = sum_addr;
        entry_upd.resolved = 1'b1;
        proc_emit          = entry.is_store;
      end
    end else begin
      proc_emit = !stop && !entry.is_store && entry.resolved;
    end
    proc_keep = !proc_emit;
  end

  assign stall = proc_emit && !estat.can_push;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_in.kind == KIND_BCAST) begin
            state_next = ST_READ;
          end else if (req_in.kind == KIND_ISSUE && !(req_in.is_store &&
                       req_in.operand_ready) && (count < PTR_W'(BUFFER_DEPTH)) &&
                       req_in.operand_ready) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_READ: begin
        if (pass_done) begin
          state_next = (pass == PASS_BCAST) ? ST_READ : ST_FIN;
        end else begin
          state_next = ST_PROC;
        end
      end
      ST_PROC: begin
        if (!stall) begin
          state_next = ST_READ;
        end
      end
      ST_FIN: begin
        if (!estat.hold_valid || estat.can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM and output stage controls.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr[IDX_W-1:0];
    mem_wdata = ENTRY_W'(entry_upd);
    mem_re    = 1'b0;
    ereq      = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && req_in.kind == KIND_ISSUE) begin
          if (req_in.is_store && req_in.operand_ready) begin
            ereq.push                = 1'b1;
            ereq.data.status         = STATUS_OK;
            ereq.data.to_load_buffer = 1'b0;
            ereq.data.entry_rob      = req_in.rob_index;
            ereq.data.address        = 32'(req_in.offset + req_in.src_value);
          end else if (count >= PTR_W'(BUFFER_DEPTH)) begin
            ereq.push                = 1'b1;
            ereq.data.status         = STATUS_OVERFLOW;
            ereq.data.to_load_buffer = 1'b0;
            ereq.data.entry_rob      = req_in.rob_index;
            ereq.data.address        = '0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count[IDX_W-1:0];
            mem_wdata = ENTRY_W'(new_entry);
          end
        end
      end
      ST_READ: begin
        mem_re = !pass_done;
      end
      ST_PROC: begin
        if (!stall) begin
          mem_we = proc_keep;
          if (proc_emit) begin
            ereq.push                = 1'b1;
            ereq.data.status         = STATUS_OK;
            ereq.data.to_load_buffer = (pass == PASS_REL);
            ereq.data.entry_rob      = entry.rob;
            ereq.data.address        = entry_upd.addr;
          end
        end
      end
      ST_FIN: begin
        ereq.finish = 1'b1;
      end
      default: ;
    endcase
  end

  // Buffer fill, scan pointers and latched broadcast fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      pass   <= PASS_BCAST;
      stop   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          rd_ptr <= '0;
          wr_ptr <= '0;
          stop   <= 1'b0;
          if (accept) begin
            case (req_in.kind)
              KIND_ISSUE: begin
                if (!(req_in.is_store && req_in.operand_ready) &&
                    count < PTR_W'(BUFFER_DEPTH)) begin
                  count <= count + 1'b1;
                  pass  <= PASS_REL;
                end
              end
              KIND_BCAST: begin
                pass     <= PASS_BCAST;
                bc_tag   <= TAG_BITS'(req_in.src_tag);
                bc_value <= req_in.src_value;
              end
              KIND_FLUSH: count <= '0;
              default: ;
            endcase
          end
        end
        ST_READ: begin
          if (pass_done) begin
            count <= wr_ptr;
            if (pass == PASS_BCAST) begin
              pass   <= PASS_REL;
              rd_ptr <= '0;
              wr_ptr <= '0;
              stop   <= 1'b0;
            end
          end
        end
        ST_PROC: begin
          if (!stall) begin
            rd_ptr <= rd_ptr + 1'b1;
            if (proc_keep) begin
              wr_ptr <= wr_ptr + 1'b1;
            end
            if (pass == PASS_REL && entry.is_store) begin
              stop <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The fill count never passes the buffer depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PTR_W'(BUFFER_DEPTH))
    else $error("pending count beyond buffer depth");

  // Compaction never writes ahead of the entry being read.
  a_wr_behind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROC) |-> (wr_ptr <= rd_ptr && rd_ptr < count))
    else $error("scan pointers out of order");

  // No result of a finished request is left held when a new one is taken.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !estat.hold_valid)
    else $error("held result left over at idle");

endmodule

### hdl/lsau_ram.sv
// ----------------------------------------------------------------------------
// lsau_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsau_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/lsau_outstage.sv
// ----------------------------------------------------------------------------
// lsau_outstage
// Holds the newest result until the next one or the end of the request
// shows whether it is the last, and drives the result register.
// ----------------------------------------------------------------------------
module lsau_outstage import lsau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  emit_req_t  req,
  output emit_stat_t stat,
  lsau_res_if.source res
);

  logic    hold_valid;
  result_t hold;
  logic    out_free;
  logic    can_push;
  logic    send_hold;

  assign out_free        = !res.valid || res.ready;
  assign can_push        = !hold_valid || out_free;
  assign send_hold       = hold_valid && out_free && (req.push || req.finish);
  assign stat.can_push   = can_push;
  assign stat.hold_valid = hold_valid;

  // Hold register and result register. The held result goes out as last
  // only when the request finishes instead of pushing another one.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      if (send_hold) begin
        res.valid          <= 1'b1;
        res.status         <= hold.status;
        res.to_load_buffer <= hold.to_load_buffer;
        res.entry_rob      <= hold.entry_rob;
        res.address        <= hold.address;
        res.last           <= !req.push;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (req.push && can_push) begin
        hold       <= req.data;
        hold_valid <= 1'b1;
      end else if (send_hold) begin
        hold_valid <= 1'b0;
      end
    end
  end

endmodule

### tb/tb_lsau_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsau_channels
// Helpers shared by the address unit testbench: a record of one expected
// address result.
// ----------------------------------------------------------------------------
package tb_lsau_types_pkg;

  // One expected result, including its last mark.
  typedef struct packed {
    logic        status;
    logic        to_load_buffer;
    logic [5:0]  entry_rob;
    logic [31:0] address;
    logic        last;
  } addr_result_t;

endpackage

### tb/tb_load_store_address_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_load_store_address_unit_top
// Self-checking testbench for the load/store address unit.
// ----------------------------------------------------------------------------
// Requests come first from directed sequences and then from a random mix of
// issues, broadcasts, flushes and unused kinds. A behavioral copy of the
// pending buffer works out the released addresses for every accepted request.
// Each result is compared field by field against the oldest outstanding
// expectation. Both channels idle in random bursts, not in the final stretch.
module tb_load_store_address_unit_top;
  import lsau_pkg::*;
  import tb_lsau_types_pkg::*;

  localparam int N_RANDOM = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_TAIL = 60;

  // Request kind that the unit ignores.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst;

  lsau_req_if req_ch ();
  lsau_res_if res_ch ();

  load_store_address_unit_top dut (
    .clk(clk),
    .rst(rst),
    .req_in(req_ch.sink),
    .res_out(res_ch.source)
  );

  // One request as it is placed on the channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic        is_store;
    logic [31:0] offset;
    logic        operand_ready;
    logic [5:0]  src_tag;
    logic [31:0] src_value;
    logic [5:0]  rob_index;
  } addr_req_t;

  // Directed row: a request and, where obvious, a single expected result.
  typedef struct {
    addr_req_t    req;
    bit           has_fixed;
    addr_result_t fixed;
  } dir_row_t;

  // Behavioral copy of the pending buffer.
  typedef struct {
    bit          is_store;
    bit          resolved;
    logic [5:0]  tag;
    logic [5:0]  rob;
    logic [31:0] addr;
  } slot_t;

  slot_t        pend_q[$];
  addr_result_t expected_q[$];
  addr_result_t released[$];

  int  mismatch_count;
  int  cycle_count;
  bit  quiet;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Queue a released address from the pending buffer model.
  function automatic void note_release(bit to_load, logic [5:0] rob, logic [31:0] addr);
    addr_result_t r;
    r.status = STATUS_OK;
    r.to_load_buffer = to_load;
    r.entry_rob = rob;
    r.address = addr;
    r.last = 1'b0;
    released.insert(released.size(), r);
  endfunction

  // Release every resolved load ahead of the first buffered store.
  function automatic void drain_resolved_loads();
    int i;
    i = 0;
    while (i < pend_q.size() && !pend_q[i].is_store) begin
      if (pend_q[i].resolved) begin
        note_release(1'b1, pend_q[i].rob, pend_q[i].addr);
        pend_q.delete(i);
      end else begin
        i++;
      end
    end
  endfunction

  // Predict the results of one accepted request.
  function automatic void predict_addresses(addr_req_t rq);
    slot_t s;
    bit hit;
    int i;
    released.delete();
    case (rq.kind)
      KIND_ISSUE: begin
        if (rq.is_store && rq.operand_ready) begin
          note_release(1'b0, rq.rob_index, rq.offset + rq.src_value);
        end else if (pend_q.size() >= BUFFER_DEPTH) begin
          addr_result_t r;
          r = '0;
          r.status = STATUS_OVERFLOW;
          r.entry_rob = rq.rob_index;
          released.insert(released.size(), r);
        end else begin
          s.is_store = rq.is_store;
          s.resolved = rq.operand_ready;
          s.tag = rq.src_tag;
          s.rob = rq.rob_index;
          s.addr = rq.operand_ready ? rq.offset + rq.src_value : rq.offset;
          pend_q.insert(pend_q.size(), s);
          if (rq.operand_ready) drain_resolved_loads();
        end
      end
      KIND_BCAST: begin
        hit = 0;
        i = 0;
        while (i < pend_q.size()) begin
          if (!pend_q[i].resolved && pend_q[i].tag == rq.src_tag) begin
            hit = 1;
            pend_q[i].addr = pend_q[i].addr + rq.src_value;
            if (pend_q[i].is_store) begin
              note_release(1'b0, pend_q[i].rob, pend_q[i].addr);
              pend_q.delete(i);
              continue;
            end
            pend_q[i].resolved = 1;
          end
          i++;
        end
        if (hit) drain_resolved_loads();
      end
      KIND_FLUSH: begin
        pend_q.delete();
      end
      default: begin
      end
    endcase
    if (released.size() > 0) released[released.size()-1].last = 1'b1;
    foreach (released[k]) expected_q.insert(expected_q.size(), released[k]);
  endfunction

  // Compare one observed result against the oldest expectation.
  function automatic void check_result(addr_result_t got);
    addr_result_t want;
    if (expected_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Unexpected result: %p", got);
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Result mismatch: expected %p, got %p", want, got);
    end
  endfunction

  // Result side: random stalls in bursts, checks on each accepted result.
  initial begin
    int burst;
    addr_result_t got;
    res_ch.ready = 1'b0;
    burst = 0;
    @(posedge clk);
    while (1) begin
      if (res_ch.valid && res_ch.ready) begin
        got.status = res_ch.status;
        got.to_load_buffer = res_ch.to_load_buffer;
        got.entry_rob = res_ch.entry_rob;
        got.address = res_ch.address;
        got.last = res_ch.last;
        check_result(got);
      end
      if (rst || quiet) begin
        res_ch.ready <= ~rst;
      end else if (burst > 0) begin
        burst--;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 14) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Drive one request and wait until the unit takes it. Valid stays high
  // between requests that follow without a gap.
  task automatic send_request(addr_req_t rq);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= rq.kind;
    req_ch.is_store <= rq.is_store;
    req_ch.offset <= rq.offset;
    req_ch.operand_ready <= rq.operand_ready;
    req_ch.src_tag <= rq.src_tag;
    req_ch.src_value <= rq.src_value;
    req_ch.rob_index <= rq.rob_index;
    do @(posedge clk); while (!req_ch.ready);
    predict_addresses(rq);
  endtask

  function automatic addr_req_t mk_issue(bit st, logic [31:0] off, bit rdy,
                                         logic [5:0] tag, logic [31:0] val,
                                         logic [5:0] rob);
    addr_req_t r;
    r.kind = KIND_ISSUE;
    r.is_store = st;
    r.offset = off;
    r.operand_ready = rdy;
    r.src_tag = tag;
    r.src_value = val;
    r.rob_index = rob;
    return r;
  endfunction

  function automatic addr_req_t mk_other(logic [1:0] kind, logic [5:0] tag,
                                         logic [31:0] val);
    addr_req_t r;
    r = '0;
    r.kind = kind;
    r.src_tag = tag;
    r.src_value = val;
    return r;
  endfunction

  // Random request: mostly issues against a small tag set so broadcasts match.
  function automatic addr_req_t random_request();
    int pick;
    logic [5:0] tag;
    pick = $urandom_range(0, 99);
    tag = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
    if (pick < 55)
      return mk_issue(1'($urandom), $urandom, $urandom_range(0, 2) == 0, tag,
                      $urandom, 6'($urandom));
    else if (pick < 92)
      return mk_other(KIND_BCAST, tag, $urandom);
    else if (pick < 97)
      return mk_other(KIND_FLUSH, 6'($urandom), $urandom);
    else
      return mk_other(KIND_UNUSED, 6'($urandom), $urandom);
  endfunction

  // Stimulus: directed table, buffer fill and overflow, then random requests, then drain.
  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    int waited;
    mismatch_count = 0;
    cycle_count = 0;
    quiet = 0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_FLUSH;
    req_ch.is_store = 1'b0;
    req_ch.offset = '0;
    req_ch.operand_ready = 1'b0;
    req_ch.src_tag = '0;
    req_ch.src_value = '0;
    req_ch.rob_index = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Ready stores at the extremes, wrapping in 32 bits.
    row.has_fixed = 1;
    row.req = mk_issue(1, 32'h7fffffff, 1, 6'd0, 32'h00000001, 6'd63);
    row.fixed = '{STATUS_OK, 1'b0, 6'd63, 32'h80000000, 1'b1};
    rows.insert(rows.size(), row);
    row.req = mk_issue(1, 32'h80000000, 1, 6'd63, 32'hffffffff, 6'd0);
    row.fixed = '{STATUS_OK, 1'b0, 6'd0, 32'h7fffffff, 1'b1};
    rows.insert(rows.size(), row);
    // Ready load released at once from an empty buffer.
    row.req = mk_issue(0, 32'h00000010, 1, 6'd5, 32'h00000100, 6'd7);
    row.fixed = '{STATUS_OK, 1'b1, 6'd7, 32'h00000110, 1'b1};
    rows.insert(rows.size(), row);
    // Waiting store and load, a ready load behind a store, then broadcasts.
    row.has_fixed = 0;
    rows.insert(rows.size(), '{mk_issue(1, 32'h4, 0, 6'd9, 32'h0, 6'd1), 0, '0});
    rows.insert(rows.size(), '{mk_issue(0, 32'h8, 0, 6'd9, 32'h0, 6'd2), 0, '0});
    rows.insert(rows.size(), '{mk_issue(0, 32'hc, 1, 6'd0, 32'h10, 6'd3), 0, '0});
    rows.insert(rows.size(), '{mk_other(KIND_BCAST, 6'd33, 32'h55), 0, '0});
    rows.insert(rows.size(), '{mk_other(KIND_BCAST, 6'd9, 32'hffffffff), 0, '0});
    rows.insert(rows.size(), '{mk_other(KIND_BCAST, 6'd9, 32'h1), 0, '0});
    rows.insert(rows.size(), '{mk_other(KIND_UNUSED, 6'd9, 32'h1), 0, '0});
    // Waiting load then a flush drops it.
    rows.insert(rows.size(), '{mk_issue(0, 32'h0, 0, 6'd63, 32'h0, 6'd4), 0, '0});
    rows.insert(rows.size(), '{mk_other(KIND_FLUSH, 6'd0, 32'h0), 0, '0});
    rows.insert(rows.size(), '{mk_other(KIND_BCAST, 6'd63, 32'h1), 0, '0});
    foreach (rows[k]) begin
      send_request(rows[k].req);
      if (rows[k].has_fixed) begin
        // Replace the predicted entry with the value typed in the table.
        void'(expected_q.pop_back());
        expected_q.insert(expected_q.size(), rows[k].fixed);
      end
    end
    // Fill the buffer, then overflow with a load and a waiting store.
    for (int k = 0; k < BUFFER_DEPTH; k++)
      send_request(mk_issue(k[0], 32'($urandom), 0, 6'd20 + 6'(k % 2), 32'h0, 6'(k)));
    send_request(mk_issue(0, 32'h1234, 0, 6'd1, 32'h0, 6'd40));
    void'(expected_q.pop_back());
    expected_q.insert(expected_q.size(), '{STATUS_OVERFLOW, 1'b0, 6'd40, 32'h0, 1'b1});
    send_request(mk_issue(1, 32'h1234, 0, 6'd1, 32'h0, 6'd41));
    void'(expected_q.pop_back());
    expected_q.insert(expected_q.size(), '{STATUS_OVERFLOW, 1'b0, 6'd41, 32'h0, 1'b1});
    send_request(mk_issue(1, 32'h1, 1, 6'd1, 32'h1, 6'd42));
    send_request(mk_other(KIND_BCAST, 6'd21, 32'h1000));
    send_request(mk_other(KIND_BCAST, 6'd20, 32'h2000));

    // Random part; the last stretch runs without idling.
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 40) quiet = 1;
      send_request(random_request());
    end
    req_ch.valid <= 1'b0;

    waited = 0;
    while (expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (QUIET_TAIL) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
